@@ hdl/bmr_pkg.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bmr_pkg
// Shared codes, constants and small helpers for the bank mapper with RTC.
// ----------------------------------------------------------------------------
package bmr_pkg;

	typedef enum logic [1:0] {
		CMD_READ  = 2'd0,
		CMD_WRITE = 2'd1,
		CMD_TICK  = 2'd2,
		CMD_NOP   = 2'd3
	} cmd_t;

	typedef enum logic [1:0] {
		KIND_NONE = 2'd0,
		KIND_ROM  = 2'd1,
		KIND_RAM  = 2'd2,
		KIND_RTC  = 2'd3
	} kind_t;

	// configuration register indexes
	localparam logic CFG_ROM_BANK_COUNT = 1'b0;
	localparam logic CFG_RAM_SIZE       = 1'b1;

	localparam logic [7:0]  ROM_BANK_COUNT_RST = 8'd128;
	localparam logic [15:0] RAM_SIZE_RST       = 16'd32768;

	localparam logic [3:0] RAM_EN_KEY   = 4'hA;
	localparam logic [7:0] RAM_SEL_LAST = 8'h03;
	localparam logic [7:0] RTC_SEL_FIRST = 8'h08;
	localparam logic [7:0] RTC_SEL_LAST  = 8'h0C;
	localparam logic [7:0] LATCH_ARM    = 8'h00;
	localparam logic [7:0] LATCH_FIRE   = 8'h01;
	localparam logic [7:0] OPEN_BUS     = 8'hFF;

	localparam int RTC_REGS  = 5;
	localparam int RTC_DH    = 4;   // day high byte
	localparam int HALT_BIT  = 6;
	localparam int CARRY_BIT = 7;

	localparam int SEC_PER_MIN = 60;
	localparam int HR_PER_DAY  = 24;

	typedef logic [RTC_REGS-1:0][7:0] rtc_regs_t;

	// quotient by 60 for t <= 259 (compare ladder)
	function automatic logic [2:0] div60(input logic [8:0] t);
		logic [2:0] q;
		q = '0;
		for (int i = 1; i <= 4; i++) begin
			if (t >= 9'(i * SEC_PER_MIN)) q = 3'(i);
		end
		return q;
	endfunction

	// quotient by 24 for t <= 259
	function automatic logic [3:0] div24(input logic [8:0] t);
		logic [3:0] q;
		q = '0;
		for (int i = 1; i <= 10; i++) begin
			if (t >= 9'(i * HR_PER_DAY)) q = 4'(i);
		end
		return q;
	endfunction

endpackage
`default_nettype wire

@@ hdl/bank_mapper_with_rtc.sv @@
`default_nettype none
// ----------------------------------------------------------------------------
// bank_mapper_with_rtc
// Cartridge bank controller with a real-time clock: maps bus accesses, holds
// the bank and RTC select registers and advances the clock on ticks while it is not halted.
// ----------------------------------------------------------------------------
// Each accepted input word is held in the input register, then its result in the
// result register, which drives the result stream.
// Throughput: one word per cycle while the result stream is not stalled, set
// by the single combinational pass between the two registers.
// Reset (arst_n low, asynchronous): ROM bank 1, RAM disabled, RAM bank 0,
// no RTC register selected, latch armed, clock all zero, config at defaults.
module bank_mapper_with_rtc import bmr_pkg::*; #(
	parameter int ROM_BANK_BITS = 7,
	parameter int RAM_BANK_BITS = 2
) (
	input  wire logic        clk,
	input  wire logic        arst_n,
	// configuration
	input  wire logic        cfg_we,
	input  wire logic        cfg_index,
	input  wire logic [15:0] cfg_wdata,
	// input stream
	input  wire logic        s_axis_tvalid,
	output logic             s_axis_tready,
	input  wire logic [23:0] s_axis_tdata,   // address[15:0], data[23:16]
	input  wire logic [1:0]  s_axis_tuser,   // command[1:0]
	// result stream
	output logic             m_axis_tvalid,
	input  wire logic        m_axis_tready,
	output logic [31:0]      m_axis_tdata,   // memory_address[20:0], write_enable[21],
	                                         // read_data[29:22], zero[31:30]
	output logic [1:0]       m_axis_tuser    // result_kind[1:0]
);

	localparam int RB_W = (RAM_BANK_BITS > 0) ? RAM_BANK_BITS : 1;
	localparam logic [RB_W-1:0] RB_MASK = RB_W'((1 << RAM_BANK_BITS) - 1);

	// config and controller state
	logic [7:0]               rom_bank_count_q;
	logic [15:0]              ram_size_q;
	logic                     ram_enabled_q, ram_enabled_d;
	logic [ROM_BANK_BITS-1:0] rom_bank_q, rom_bank_d;
	logic [RB_W-1:0]          ram_bank_q, ram_bank_d;
	logic [3:0]               rtc_select_q, rtc_select_d;
	logic                     latch_prev_zero_q, latch_prev_zero_d;
	rtc_regs_t                clock_live_q, clock_live_d;
	rtc_regs_t                clock_latched_q, clock_latched_d;

	// input stage
	logic        valid_s1;
	cmd_t        cmd_s1;
	logic [15:0] addr_s1;
	logic [7:0]  data_s1;

	// result stage
	logic        valid_s2;
	kind_t       kind_s2, kind_d;
	logic [20:0] maddr_s2, maddr_d;
	logic        we_s2, we_d;
	logic [7:0]  rdata_s2, rdata_d;

	logic advance;
	assign advance       = !valid_s2 || m_axis_tready;
	assign s_axis_tready = !valid_s1 || advance;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			cmd_s1  <= cmd_t'(s_axis_tuser);
			addr_s1 <= s_axis_tdata[15:0];
			data_s1 <= s_axis_tdata[23:16];
		end
	end

	// clock tick datapath
	rtc_regs_t  tick_val;
	logic [8:0] t_sec, t_min, t_hr;
	logic [2:0] q_sec, q_min;
	logic [3:0] q_hr;
	logic [9:0] days;

	always_comb begin
		t_sec = 9'(clock_live_q[0]) + 9'd1;
		q_sec = div60(t_sec);
		t_min = 9'(clock_live_q[1]) + 9'(q_sec);
		q_min = div60(t_min);
		t_hr  = 9'(clock_live_q[2]) + 9'(q_min);
		q_hr  = div24(t_hr);
		days  = 10'({clock_live_q[RTC_DH][0], clock_live_q[3]}) + 10'(q_hr);

		tick_val    = clock_live_q;
		tick_val[0] = 8'(t_sec - 9'(q_sec) * 9'(SEC_PER_MIN));
		tick_val[1] = 8'(t_min - 9'(q_min) * 9'(SEC_PER_MIN));
		tick_val[2] = 8'(t_hr - 9'(q_hr) * 9'(HR_PER_DAY));
		tick_val[3] = days[7:0];
		tick_val[RTC_DH][0] = days[8];
		tick_val[RTC_DH][CARRY_BIT] = clock_live_q[RTC_DH][CARRY_BIT] | days[9];
	end

	// item processing
	logic [ROM_BANK_BITS-1:0] rom_sel;
	logic [6:0]               rom_bank_ext;
	logic [1:0]               ram_bank_ext;
	logic [14:0]              ram_off;
	logic                     rtc_sel_ok;
	logic [2:0]               rtc_idx;
	logic                     do_step;

	always_comb begin
		do_step = valid_s1 && advance;

		ram_enabled_d     = ram_enabled_q;
		rom_bank_d        = rom_bank_q;
		ram_bank_d        = ram_bank_q;
		rtc_select_d      = rtc_select_q;
		latch_prev_zero_d = latch_prev_zero_q;
		clock_live_d      = clock_live_q;
		clock_latched_d   = clock_latched_q;

		kind_d  = KIND_NONE;
		maddr_d = '0;
		we_d    = 1'b0;
		rdata_d = OPEN_BUS;

		rom_sel      = addr_s1[14] ? rom_bank_q : '0;
		rom_bank_ext = 7'(rom_sel);
		ram_bank_ext = 2'(ram_bank_q & RB_MASK);
		ram_off      = {ram_bank_ext, addr_s1[12:0]};
		rtc_sel_ok   = (8'(rtc_select_q) >= RTC_SEL_FIRST) &&
		               (8'(rtc_select_q) <= RTC_SEL_LAST);
		rtc_idx      = rtc_select_q[2:0];

		case (cmd_s1)
			CMD_TICK: begin
				if (!clock_live_q[RTC_DH][HALT_BIT]) clock_live_d = tick_val;
			end
			CMD_READ, CMD_WRITE: begin
				if (!addr_s1[15]) begin
					if (cmd_s1 == CMD_WRITE) begin
						case (addr_s1[14:13])
							2'd0: ram_enabled_d = (data_s1[3:0] == RAM_EN_KEY);
							2'd1: begin
								rom_bank_d = (data_s1[ROM_BANK_BITS-1:0] == '0) ?
								             ROM_BANK_BITS'(1) : data_s1[ROM_BANK_BITS-1:0];
							end
							2'd2: begin
								if (data_s1 <= RAM_SEL_LAST) begin
									ram_bank_d   = data_s1[RB_W-1:0] & RB_MASK;
									rtc_select_d = '0;
								end else if (data_s1 >= RTC_SEL_FIRST &&
								             data_s1 <= RTC_SEL_LAST) begin
									rtc_select_d = data_s1[3:0];
								end
							end
							default: begin
								if (data_s1 == LATCH_FIRE && latch_prev_zero_q)
									clock_latched_d = clock_live_q;
								latch_prev_zero_d = (data_s1 == LATCH_ARM);
							end
						endcase
					end else if ({1'b0, rom_bank_ext} < rom_bank_count_q) begin
						kind_d  = KIND_ROM;
						maddr_d = {rom_bank_ext, addr_s1[13:0]};
						rdata_d = '0;
					end
				end else if (addr_s1[15:13] == 3'b101 && ram_enabled_q) begin
					if (rtc_sel_ok) begin
						if (cmd_s1 == CMD_READ) begin
							kind_d  = KIND_RTC;
							rdata_d = clock_latched_q[rtc_idx];
						end else begin
							clock_live_d[rtc_idx] = data_s1;
						end
					end else if ({1'b0, ram_off} < ram_size_q) begin
						kind_d  = KIND_RAM;
						maddr_d = 21'(ram_off);
						we_d    = (cmd_s1 == CMD_WRITE);
						rdata_d = '0;
					end
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			rom_bank_count_q  <= ROM_BANK_COUNT_RST;
			ram_size_q        <= RAM_SIZE_RST;
			ram_enabled_q     <= 1'b0;
			rom_bank_q        <= ROM_BANK_BITS'(1);
			ram_bank_q        <= '0;
			rtc_select_q      <= '0;
			latch_prev_zero_q <= 1'b1;
			clock_live_q      <= '0;
			clock_latched_q   <= '0;
		end else begin
			if (cfg_we) begin
				if (cfg_index == CFG_ROM_BANK_COUNT) rom_bank_count_q <= cfg_wdata[7:0];
				else                                 ram_size_q       <= cfg_wdata;
			end
			if (do_step) begin
				ram_enabled_q     <= ram_enabled_d;
				rom_bank_q        <= rom_bank_d;
				ram_bank_q        <= ram_bank_d;
				rtc_select_q      <= rtc_select_d;
				latch_prev_zero_q <= latch_prev_zero_d;
				clock_live_q      <= clock_live_d;
				clock_latched_q   <= clock_latched_d;
			end
		end
	end

	// result register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s2 <= 1'b0;
		end else if (advance) begin
			valid_s2 <= valid_s1;
		end
	end

	always_ff @(posedge clk) begin
		if (do_step) begin
			kind_s2  <= kind_d;
			maddr_s2 <= maddr_d;
			we_s2    <= we_d;
			rdata_s2 <= rdata_d;
		end
	end

	assign m_axis_tvalid = valid_s2;
	assign m_axis_tuser  = kind_s2;
	assign m_axis_tdata  = {2'b00, rdata_s2, we_s2, maddr_s2};

`ifndef SYNTHESIS
	a_we_only_ram: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tdata[21]) |-> (m_axis_tuser == KIND_RAM))
		else $error("write strobe on a non-RAM result");

	a_open_bus: assert property (@(posedge clk) disable iff (!arst_n)
		(m_axis_tvalid && m_axis_tuser == KIND_NONE) |->
		(m_axis_tdata[29:22] == OPEN_BUS && m_axis_tdata[20:0] == '0))
		else $error("open bus result not 0xFF at address 0");

	a_halt_holds: assert property (@(posedge clk) disable iff (!arst_n)
		(do_step && cmd_s1 == CMD_TICK && clock_live_q[RTC_DH][HALT_BIT]) |=>
		$stable(clock_live_q))
		else $error("halted clock advanced");

	a_rom_bank_nonzero: assert property (@(posedge clk) disable iff (!arst_n)
		do_step |=> (rom_bank_q != '0))
		else $error("ROM bank register holds zero");
`endif

endmodule
`default_nettype wire
